// ===== design/zd3_pkg.sv =====
`default_nettype none

package zd3_pkg;

  localparam int PIX_W        = 8;
  localparam int FRAME_W_BITS = 11;
  localparam int FRAME_H_BITS = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_EIGHT_CONNECTED = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_t;

  // Which neighbors of the output pixel lie inside the frame
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } nbr_mask_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/zero_dilation_3x3_stream.sv =====
// Result order: the result for a pixel is registered into the output buffer when the item that lies
//   one row and one column later in raster order is accepted (frame_width + 1 items behind).
// Throughput: one item per cycle; input stalls only while the skid register holds an item.
//   Each item takes one line memory read, and a pixel item that is not dropped one write.
// Reset: clears position counters, the output buffer, and loads default configuration.
//   Line memory and window contents are not cleared; border masking hides stale data.
`default_nettype none

module zero_dilation_3x3_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [zd3_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
  input  wire logic [0:0]                     s_axis_tuser,   // [0] kind
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [zd3_pkg::PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_out
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [zd3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [zd3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import zd3_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW   = $clog2(MAX_WIDTH + 2);
  localparam int WCB  = $clog2(MAX_WIDTH + 1);
  localparam int HCB  = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP = (WCB > FRAME_W_BITS) ? WCB : FRAME_W_BITS;
  localparam int HCMP = (HCB > FRAME_H_BITS) ? HCB : FRAME_H_BITS;
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  // Configuration, kept as last column / last row indexes
  logic [AW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic          eight_connected;

  logic [AW-1:0] in_column, in_column_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [PW-1:0] pending, pending_next;
  logic [AW-1:0] out_col, out_col_next;
  logic [RW-1:0] out_row, out_row_next;
  logic          frame_received, frame_received_next;

  logic [WCMP-1:0] w_val;
  logic [HCMP-1:0] h_val;
  logic [AW-1:0]   last_col_wr;
  logic [RW-1:0]   last_row_wr;
  logic            cfg_hit;

  logic            accept, active, is_drain, emit, last_pix, col_wrap;
  logic [PW-1:0]   pend_full;
  logic [PIX_W:0]  rd_data;
  logic [PIX_W:0]  wr_data;
  logic [PIX_W-1:0] mid_pix;
  logic            top_zero, bot_zero;
  logic            buf_ready;
  nbr_mask_t       nbr;
  out_item_t       push_item, m_item;
  logic [PIX_W-1:0] result_pix;

  // Clamp written geometry into 1..MAX
  always_comb begin
    w_val = WCMP'(cfg_data[FRAME_W_BITS-1:0]);
    h_val = HCMP'(cfg_data[FRAME_H_BITS-1:0]);
    if (w_val == '0) begin
      last_col_wr = '0;
    end else if (w_val > WCMP'(MAX_WIDTH)) begin
      last_col_wr = AW'(MAX_WIDTH - 1);
    end else begin
      last_col_wr = AW'(w_val - WCMP'(1));
    end
    if (h_val == '0) begin
      last_row_wr = '0;
    end else if (h_val > HCMP'(MAX_HEIGHT)) begin
      last_row_wr = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row_wr = RW'(h_val - HCMP'(1));
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_EIGHT_CONNECTED: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col        <= AW'(RST_W - 1);
      last_row        <= RW'(RST_H - 1);
      eight_connected <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     last_col        <= last_col_wr;
        REG_FRAME_HEIGHT:    last_row        <= last_row_wr;
        REG_EIGHT_CONNECTED: eight_connected <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = buf_ready;
  assign accept        = s_axis_tvalid && buf_ready;
  assign is_drain      = (kind_t'(s_axis_tuser[0]) == KIND_DRAIN);
  // Drop a pixel after a full frame and a drain before one
  assign active        = accept && (is_drain == frame_received);
  assign pend_full     = PW'(last_col) + PW'(3);
  assign emit          = active && (pending == pend_full - PW'(1));
  assign last_pix      = (out_row == last_row) && (out_col == last_col);
  assign col_wrap      = (in_column == last_col);

  always_comb begin
    in_column_next      = in_column;
    in_row_next         = in_row;
    pending_next        = pending;
    out_col_next        = out_col;
    out_row_next        = out_row;
    frame_received_next = frame_received;
    if (cfg_hit) begin
      in_column_next      = '0;
      in_row_next         = '0;
      pending_next        = '0;
      out_col_next        = '0;
      out_row_next        = '0;
      frame_received_next = 1'b0;
    end else if (active) begin
      in_column_next = col_wrap ? '0 : in_column + AW'(1);
      if (!is_drain && col_wrap) begin
        if (in_row == last_row) begin
          frame_received_next = 1'b1;
        end else begin
          in_row_next = in_row + RW'(1);
        end
      end
      if (!emit) begin
        pending_next = pending + PW'(1);
      end else if (last_pix) begin
        in_column_next      = '0;
        in_row_next         = '0;
        pending_next        = '0;
        out_col_next        = '0;
        out_row_next        = '0;
        frame_received_next = 1'b0;
      end else if (out_col == last_col) begin
        out_col_next = '0;
        out_row_next = out_row + RW'(1);
      end else begin
        out_col_next = out_col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column      <= '0;
      in_row         <= '0;
      pending        <= '0;
      out_col        <= '0;
      out_row        <= '0;
      frame_received <= 1'b0;
    end else begin
      in_column      <= in_column_next;
      in_row         <= in_row_next;
      pending        <= pending_next;
      out_col        <= out_col_next;
      out_row        <= out_row_next;
      frame_received <= frame_received_next;
    end
  end

  // Entry holds {zero mark of the row above, pixel of the previous row}
  assign mid_pix  = rd_data[PIX_W-1:0];
  assign top_zero = rd_data[PIX_W];
  assign bot_zero = !is_drain && (s_axis_tdata == '0);
  assign wr_data  = {(mid_pix == '0), s_axis_tdata};

  zd3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (PIX_W + 1)
  ) u_line_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (active && !is_drain),
    .wr_addr (in_column),
    .wr_data (wr_data),
    .rd_addr (in_column_next),
    .rd_data (rd_data)
  );

  always_comb begin
    nbr.top    = (out_row != '0);
    nbr.bottom = (out_row != last_row);
    nbr.left   = (out_col != '0);
    nbr.right  = (out_col != last_col);
  end

  zd3_window u_window (
    .clk             (clk),
    .shift           (active),
    .top_zero        (top_zero),
    .mid_pix         (mid_pix),
    .bot_zero        (bot_zero),
    .eight_connected (eight_connected),
    .nbr             (nbr),
    .result_pix      (result_pix)
  );

  always_comb begin
    push_item.pixel = result_pix;
    push_item.last  = last_pix;
  end

  zd3_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_item (push_item),
    .ready     (buf_ready),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_item    (m_item)
  );

  assign m_axis_tdata = m_item.pixel;
  assign m_axis_tlast = m_item.last;

`ifndef SYNTHESIS
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending < pend_full)
    else $error("pending item count ran past one row plus one");

  a_frame_end_restart: assert property (@(posedge clk) disable iff (rst)
    (emit && last_pix && !cfg_hit) |=> (in_column == '0 && pending == '0 && !frame_received))
    else $error("frame counters not restarted after the final item");
`endif

endmodule

`default_nettype wire

// ===== design/zd3_line_mem.sv =====
`default_nettype none

module zd3_line_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q;
  logic [DW-1:0] fwd_data;
  logic          fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q    <= mem[rd_addr];
    fwd_data <= wr_data;
  end

  // Same-address read and write: hand back the new data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

`default_nettype wire

// ===== design/zd3_window.sv =====
`default_nettype none

module zd3_window (
  input  wire logic                     clk,
  input  wire logic                     shift,
  input  wire logic                     top_zero,
  input  wire logic [zd3_pkg::PIX_W-1:0] mid_pix,
  input  wire logic                     bot_zero,
  input  wire logic                     eight_connected,
  input  wire zd3_pkg::nbr_mask_t       nbr,
  output logic      [zd3_pkg::PIX_W-1:0] result_pix
);
  import zd3_pkg::*;

  // Top and bottom rows only matter as zero flags; the middle row keeps values
  logic             tz   [3];
  logic             bz   [3];
  logic [PIX_W-1:0] mid  [3];
  logic             tz_next  [3];
  logic             bz_next  [3];
  logic [PIX_W-1:0] mid_next [3];
  logic             zero;
  logic             diag;

  always_comb begin
    tz_next[0]  = tz[1];
    tz_next[1]  = tz[2];
    tz_next[2]  = top_zero;
    bz_next[0]  = bz[1];
    bz_next[1]  = bz[2];
    bz_next[2]  = bot_zero;
    mid_next[0] = mid[1];
    mid_next[1] = mid[2];
    mid_next[2] = mid_pix;
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      tz  <= tz_next;
      bz  <= bz_next;
      mid <= mid_next;
    end
  end

  always_comb begin
    diag = (nbr.top && nbr.left && tz_next[0]) || (nbr.top && nbr.right && tz_next[2]) ||
           (nbr.bottom && nbr.left && bz_next[0]) || (nbr.bottom && nbr.right && bz_next[2]);
    zero = (mid_next[1] == '0) ||
           (nbr.top && tz_next[1]) || (nbr.bottom && bz_next[1]) ||
           (nbr.left && (mid_next[0] == '0)) || (nbr.right && (mid_next[2] == '0)) ||
           (eight_connected && diag);
    result_pix = zero ? '0 : mid_next[1];
  end

endmodule

`default_nettype wire

// ===== design/zd3_out_skid.sv =====
`default_nettype none

module zd3_out_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire zd3_pkg::out_item_t push_item,
  output logic                    ready,
  output logic                    m_valid,
  input  wire logic               m_ready,
  output zd3_pkg::out_item_t      m_item
);
  import zd3_pkg::*;

  out_item_t skid_item;
  logic      out_valid;
  logic      skid_valid;
  logic      pop;

  assign pop     = out_valid && m_ready;
  assign ready   = !skid_valid;
  assign m_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          m_item     <= skid_item;
          skid_valid <= 1'b0;
        end else if (push) begin
          m_item <= push_item;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid) begin
          m_item    <= push_item;
          out_valid <= 1'b1;
        end else begin
          skid_item  <= push_item;
          skid_valid <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("item pushed into a full output buffer");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import zd3_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    kind_t            kind;
    logic [PIX_W-1:0] pixel;
  } pix_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata = '0;   // [7:0] pixel_in
  logic [0:0]            s_axis_tuser = '0;   // [0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;        // [7:0] pixel_out
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  zero_dilation_3x3_stream dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Pixel stream queued for the driver, and dilated pixels still owed by the block
  pix_item_t pix_feed_q[$];
  out_item_t dilated_q[$];
  int        mismatch_count = 0;
  int        fed_items = 0;
  bit        in_fire = 1'b0;

  // Shadow of the block: registers, line stores, 3x3 window and frame position
  logic [FRAME_W_BITS-1:0] width_reg;
  logic [FRAME_H_BITS-1:0] height_reg;
  logic                    eight_reg;
  logic [PIX_W-1:0]        mid_row [MAX_W];
  bit                      top_zero [MAX_W];
  logic [PIX_W-1:0]        win [9];
  int unsigned             in_row_c, in_col_c, pend_cnt, out_row_c, out_col_c;
  bit                      frame_full;

  // Frame size the stimulus generator is working with
  int unsigned gen_w, gen_h;

  // Receiver hold-off request and its countdown
  bit hold_req = 1'b0;
  int hold_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  int burst_left = 0;
  int gap_left = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_counters();
    in_row_c = 0;
    in_col_c = 0;
    pend_cnt = 0;
    out_row_c = 0;
    out_col_c = 0;
    frame_full = 1'b0;
  endfunction

  task automatic dilate_step(input kind_t kind, input logic [PIX_W-1:0] pix);
    int unsigned w, h, c;
    logic [PIX_W-1:0] top, mid, bot;
    bit tv, bv, lv, rv, zero;
    out_item_t res;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    c = (in_col_c >= MAX_W) ? 0 : in_col_c;
    top = top_zero[c] ? 8'd0 : 8'd1;
    mid = mid_row[c];
    if (kind == KIND_PIXEL) begin
      if (frame_full) return;
      bot = pix;
    end else begin
      // drain ticks bring in a nonzero bottom row that the border masks anyway
      if (!frame_full) return;
      bot = 8'd1;
    end
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bot;
    if (kind == KIND_PIXEL) begin
      top_zero[c] = (mid == 0);
      mid_row[c] = pix;
      in_col_c++;
      if (in_col_c >= w) begin
        in_col_c = 0;
        if (in_row_c + 1 >= h) frame_full = 1'b1;
        else in_row_c++;
      end
    end else begin
      in_col_c++;
      if (in_col_c >= w) in_col_c = 0;
    end
    pend_cnt++;
    if (pend_cnt < w + 2) return;
    pend_cnt--;
    tv = out_row_c > 0;
    bv = out_row_c + 1 < h;
    lv = out_col_c > 0;
    rv = out_col_c + 1 < w;
    zero = (win[4] == 0) || (tv && win[1] == 0) || (bv && win[7] == 0) ||
           (lv && win[3] == 0) || (rv && win[5] == 0);
    if (eight_reg)
      zero = zero || (tv && lv && win[0] == 0) || (tv && rv && win[2] == 0) ||
             (bv && lv && win[6] == 0) || (bv && rv && win[8] == 0);
    res.pixel = zero ? 8'd0 : win[4];
    res.last = 1'b0;
    if (out_row_c + 1 >= h && out_col_c + 1 >= w) begin
      res.last = 1'b1;
      restart_counters();
    end else begin
      out_col_c++;
      if (out_col_c >= w) begin
        out_col_c = 0;
        out_row_c++;
      end
    end
    dilated_q.insert(dilated_q.size(), res);
  endtask

  // Check results first, then predict from the item taken at this edge
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (dilated_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item pixel=%0d last=%0b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          want = dilated_q.pop_front();
          if (m_axis_tdata !== want.pixel)
            report_mismatch($sformatf("pixel_out got %0d want %0d",
                                      m_axis_tdata, want.pixel));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("frame_last got %0b want %0b",
                                      m_axis_tlast, want.last));
        end
      end
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) dilate_step(kind_t'(s_axis_tuser[0]), s_axis_tdata);
    end
  end

  // Send in bursts of random length with random gaps in between
  always @(negedge clk) begin : driver
    pix_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pix_feed_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = pix_feed_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= nxt.pixel;
        s_axis_tuser <= nxt.kind;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: a stall pattern that changes mode now and then, plus long hold-offs
  always @(negedge clk) begin : sink
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 4) < 2);
          default: m_axis_tready <= ((rx_cycle % 8) < 5);
        endcase
      end
    end
  end

  task automatic tick();
    @(posedge clk);
    #1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = val[FRAME_W_BITS-1:0];
        restart_counters();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = val[FRAME_H_BITS-1:0];
        restart_counters();
      end
      REG_EIGHT_CONNECTED: begin
        eight_reg = val[0];
        restart_counters();
      end
      default: ;
    endcase
    tick();
  endtask

  // Write all three registers; junk sets unused upper bits of the narrow ones
  task automatic set_frame(input int unsigned wv, input int unsigned hv, input bit eight,
                           input bit junk);
    logic [CFG_DATA_W-1:0] wval, eval;
    wval = CFG_DATA_W'(wv);
    eval = CFG_DATA_W'(eight);
    if (junk) begin
      wval[CFG_DATA_W-1:FRAME_W_BITS] = (CFG_DATA_W-FRAME_W_BITS)'($urandom_range(1, 3));
      eval[CFG_DATA_W-1:1] = (CFG_DATA_W-1)'($urandom_range(1, 4095));
    end
    write_reg(REG_FRAME_WIDTH, wval);
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(hv));
    write_reg(REG_EIGHT_CONNECTED, eval);
    gen_w = clamp_size(32'(wval[FRAME_W_BITS-1:0]), MAX_W);
    gen_h = clamp_size(hv, MAX_H);
  endtask

  task automatic push_item(input kind_t kind, input logic [PIX_W-1:0] pix);
    pix_item_t it;
    it.kind = kind;
    it.pixel = pix;
    pix_feed_q.insert(pix_feed_q.size(), it);
  endtask

  task automatic wait_drained();
    while (pix_feed_q.size() != 0 || s_axis_tvalid || dilated_q.size() != 0) tick();
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) tick();
  endtask

  // One frame of random pixels then its drain ticks. A nonzero cut truncates the
  // frame after that many pixels and skips the drain; pause_at holds the feed
  // mid-frame until every owed result is out.
  task automatic queue_frame(input int zero_pct, input bit noise, input int cut,
                             input int pause_at);
    int n_pix;
    logic [PIX_W-1:0] p;
    n_pix = (cut > 0) ? cut : gen_w * gen_h;
    if (noise) push_item(KIND_DRAIN, 8'($urandom));
    for (int i = 0; i < n_pix; i++) begin
      if (pause_at != 0 && i == pause_at) wait_drained();
      if ($urandom_range(0, 99) < zero_pct) p = 8'd0;
      else if ($urandom_range(0, 9) == 0) p = 8'd255;
      else p = 8'($urandom_range(1, 255));
      push_item(KIND_PIXEL, p);
      fed_items++;
    end
    if (cut == 0) begin
      if (noise) push_item(KIND_PIXEL, 8'($urandom));
      for (int i = 0; i <= gen_w; i++) begin
        push_item(KIND_DRAIN, 8'($urandom));
        fed_items++;
      end
    end
  endtask

  initial begin : run_limit
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned w, h, nframes, zp, cut;
    width_reg = 11'd1024;
    height_reg = 13'd1024;
    eight_reg = 1'b0;
    for (int i = 0; i < MAX_W; i++) begin
      mid_row[i] = '0;
      top_zero[i] = 1'b0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    restart_counters();

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    tick();

    // 3x2 frame, four neighbors: extreme pixel values and ignored items
    set_frame(3, 2, 1'b0, 1'b0);
    push_item(KIND_DRAIN, 8'hA5);         // drain before the frame: dropped
    push_item(KIND_PIXEL, 8'd0);
    push_item(KIND_PIXEL, 8'd255);
    push_item(KIND_PIXEL, 8'd1);
    push_item(KIND_PIXEL, 8'd128);
    push_item(KIND_PIXEL, 8'd127);
    push_item(KIND_PIXEL, 8'd254);
    push_item(KIND_PIXEL, 8'd0);          // pixel after a full frame: dropped
    for (int i = 0; i < 4; i++) push_item(KIND_DRAIN, 8'hFF);
    wait_idle();

    // 3x3 frame, eight neighbors, lone zero in the middle
    set_frame(3, 3, 1'b1, 1'b0);
    for (int i = 0; i < 9; i++) push_item(KIND_PIXEL, (i == 4) ? 8'd0 : 8'(200 + i));
    for (int i = 0; i < 4; i++) push_item(KIND_DRAIN, 8'h00);
    push_item(KIND_DRAIN, 8'h5A);         // drain after frame end: dropped
    wait_idle();

    // Zero sizes act as a 1x1 frame
    set_frame(0, 0, 1'b1, 1'b0);
    queue_frame(0, 1'b0, 0, 0);
    queue_frame(100, 1'b0, 0, 0);
    queue_frame(50, 1'b1, 0, 0);
    wait_idle();

    // Width above the limit acts as the widest; cut once the first results are out
    set_frame(2047, 2, 1'b0, 1'b0);
    queue_frame(10, 1'b0, 1032, 0);
    wait_idle();

    // One column, height above the limit, cut short; the spare index must change nothing
    set_frame(1, 8191, 1'b1, 1'b0);
    write_reg(REG_SPARE, 13'h1FFF);
    queue_frame(5, 1'b0, 120, 0);
    wait_idle();

    // Backpressure: long receiver hold-off, then a feed pause until all results are out
    set_frame(32, 4, 1'b1, 1'b0);
    hold_req = 1'b1;
    queue_frame(25, 1'b0, 0, 0);
    queue_frame(25, 1'b0, 0, 64);
    wait_idle();

    while (fed_items < 1600) begin
      case ($urandom_range(0, 19)) inside
        [0:12]:  w = $urandom_range(1, 8);
        [13:18]: w = $urandom_range(9, 40);
        default: w = $urandom_range(41, 200);
      endcase
      h = (w > 40) ? $urandom_range(1, 3) : $urandom_range(1, 8);
      set_frame(w, h, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      zp = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 50);
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        // a phase may end on a broken frame; the next register write restarts it
        cut = (f == nframes - 1 && $urandom_range(0, 6) == 0) ?
              $urandom_range(1, gen_w * gen_h) : 0;
        queue_frame(zp, $urandom_range(0, 4) == 0, cut, 0);
      end
      wait_idle();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) tick();
    if (dilated_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", dilated_q.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== zero_dilation_3x3_stream.f =====
design/zd3_pkg.sv
design/zd3_line_mem.sv
design/zd3_window.sv
design/zd3_out_skid.sv
design/zero_dilation_3x3_stream.sv
dv/tb_top.sv
